// ===== src/burh_pkg.sv =====
// Shared types and constants of the bounded undo and redo history.
package burh_pkg;

  localparam int ENTRY_W = 32;
  localparam int OP_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_UNDO = 2'd1,
    OP_REDO = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOKUP = 3'b010,
    ST_SEND   = 3'b100
  } state_e;

  typedef struct packed {
    logic exec;
    logic lookup;
  } cmd_t;

endpackage

// ===== src/burh_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
module burh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/burh_ctrl.sv =====
// Controller state machine that sequences accept, lookup and result delivery.
module burh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output burh_pkg::cmd_t cmd_o
);

  burh_pkg::state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      burh_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = burh_pkg::ST_LOOKUP;
        end
      end
      burh_pkg::ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = burh_pkg::ST_SEND;
      end
      burh_pkg::ST_SEND: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = burh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = burh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= burh_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/burh_datapath.sv =====
// Datapath with the cursor, end mark, ring base and the history RAM.
module burh_datapath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  burh_pkg::cmd_t                 cmd_i,
  input  logic [burh_pkg::OP_W-1:0]      op_i,
  input  logic [burh_pkg::ENTRY_W-1:0]   entry_data_i,
  output logic [burh_pkg::ENTRY_W-1:0]   current_entry_o,
  output logic                           moved_o,
  output logic                           can_undo_o,
  output logic                           can_redo_o
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (DATA_WIDTH < burh_pkg::ENTRY_W) ? DATA_WIDTH : burh_pkg::ENTRY_W;

  logic [CNT_W-1:0]      cursor_q, cursor_d;
  logic [CNT_W-1:0]      end_q, end_d;
  logic [AW-1:0]         base_q, base_d;
  logic                  moved_q, moved_d;
  logic [CNT_W-1:0]      cursor_m1;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [AW-1:0] logical);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, logical};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign cursor_m1 = cursor_q - CNT_W'(1);
  assign wdata     = DATA_WIDTH'(entry_data_i[CW-1:0]);
  assign raddr     = slot_of(base_q, cursor_m1[AW-1:0]);

  always_comb begin
    cursor_d = cursor_q;
    end_d    = end_q;
    base_d   = base_q;
    moved_d  = moved_q;
    we       = 1'b0;
    waddr    = slot_of(base_q, cursor_q[AW-1:0]);
    if (cmd_i.exec) begin
      moved_d = 1'b0;
      case (op_i)
        burh_pkg::OP_PUSH: begin
          we      = 1'b1;
          moved_d = 1'b1;
          if (cursor_q < CNT_W'(DEPTH)) begin
            cursor_d = cursor_q + CNT_W'(1);
          end else begin
            // The slot of the oldest entry becomes the new top.
            waddr  = base_q;
            base_d = slot_of(base_q, AW'(1));
          end
          end_d = (cursor_q < CNT_W'(DEPTH)) ? cursor_q + CNT_W'(1) : cursor_q;
        end
        burh_pkg::OP_UNDO: begin
          if (cursor_q > CNT_W'(1)) begin
            cursor_d = cursor_m1;
            moved_d  = 1'b1;
          end
        end
        burh_pkg::OP_REDO: begin
          if (cursor_q < end_q) begin
            cursor_d = cursor_q + CNT_W'(1);
            moved_d  = 1'b1;
          end
        end
        default: begin
          moved_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      end_q    <= '0;
      base_q   <= '0;
      moved_q  <= 1'b0;
    end else begin
      cursor_q <= cursor_d;
      end_q    <= end_d;
      base_q   <= base_d;
      moved_q  <= moved_d;
    end
  end

  burh_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.lookup),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign current_entry_o = (cursor_q == '0) ? '0 : burh_pkg::ENTRY_W'(rdata[CW-1:0]);
  assign moved_o         = moved_q;
  assign can_undo_o      = cursor_q > CNT_W'(1);
  assign can_redo_o      = cursor_q < end_q;

  a_cursor_le_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= end_q)
    else $error("cursor is above the end mark");

  a_end_le_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_q <= CNT_W'(DEPTH))
    else $error("end mark is above the depth");

  a_base_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q < AW'(DEPTH - 1) || base_q == AW'(DEPTH - 1))
    else $error("ring base is out of range");

  a_push_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && op_i == burh_pkg::OP_PUSH |=> end_q == cursor_q && cursor_q != '0 && moved_q)
    else $error("push did not leave the cursor at a nonempty end");

  a_base_only_on_full_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.exec && op_i == burh_pkg::OP_PUSH && cursor_q == CNT_W'(DEPTH)) |=> $stable(base_q))
    else $error("ring base moved without a push at the top");

endmodule

// ===== src/bounded_undo_redo_history.sv =====
// Top level of the bounded undo and redo history.
//
//   channel | direction | handshake               | words
//   in      | input     | in_valid_i, in_stall_o   | op_i, entry_data_i
//   out     | output    | out_valid_o, out_stall_i | current_entry_o, moved_o,
//           |           |                          | can_undo_o, can_redo_o
//
// A result is valid once its word has passed through the lookup state into the send state, then waits for out_stall_i.
// The lookup state reads the registered read port of the history RAM after the pointer update.
// A new input word is accepted the cycle after the previous result has been taken,
// so the block does not take a new word while an earlier one is still in flight.
// Reset clears the cursor, end mark and ring base; the RAM needs no clearing pass.
// A stalled result holds its value until it is taken.
module bounded_undo_redo_history #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [burh_pkg::OP_W-1:0]    op_i,
  input  logic [burh_pkg::ENTRY_W-1:0] entry_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [burh_pkg::ENTRY_W-1:0] current_entry_o,
  output logic                         moved_o,
  output logic                         can_undo_o,
  output logic                         can_redo_o
);

  burh_pkg::cmd_t cmd;

  burh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  burh_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .op_i            (op_i),
    .entry_data_i    (entry_data_i),
    .current_entry_o (current_entry_o),
    .moved_o         (moved_o),
    .can_undo_o      (can_undo_o),
    .can_redo_o      (can_redo_o)
  );

endmodule

// ===== dv/burh_history_checker.sv =====
// Checker that predicts every result word of the undo and redo history and compares it.
module burh_history_checker #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [burh_pkg::OP_W-1:0]    op_i,
  input  logic [burh_pkg::ENTRY_W-1:0] entry_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [burh_pkg::ENTRY_W-1:0] current_entry_i,
  input  logic                         moved_i,
  input  logic                         can_undo_i,
  input  logic                         can_redo_i,
  output int                           fail_cnt_o,
  output int                           pending_o
);
  import burh_pkg::*;

  localparam int          AW        = $clog2(DEPTH);
  localparam logic [63:0] WIDE_MASK = (DATA_WIDTH >= 64) ? '1 : (64'd1 << DATA_WIDTH) - 64'd1;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    logic               moved;
    logic               can_undo;
    logic               can_redo;
  } view_t;

  logic [ENTRY_W-1:0] hist_ring [DEPTH];
  int unsigned        cur_cnt;
  int unsigned        end_cnt;
  int unsigned        base_slot;
  view_t              pending_views [$];

  task report_mismatch(input string what, input logic [ENTRY_W-1:0] got,
                       input logic [ENTRY_W-1:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
    fail_cnt_o++;
  endtask

  task step_history(input logic [OP_W-1:0] op, input logic [ENTRY_W-1:0] data,
                    output view_t view);
    logic moved;
    moved = 1'b0;
    case (op)
      OP_PUSH: begin
        if (cur_cnt < DEPTH) begin
          hist_ring[AW'((base_slot + cur_cnt) % DEPTH)] = data & WIDE_MASK[ENTRY_W-1:0];
          cur_cnt++;
        end else begin
          // A full history drops its oldest entry by moving the ring base.
          base_slot = (base_slot + 1) % DEPTH;
          hist_ring[AW'((base_slot + DEPTH - 1) % DEPTH)] = data & WIDE_MASK[ENTRY_W-1:0];
        end
        end_cnt = cur_cnt;
        moved   = 1'b1;
      end
      OP_UNDO: begin
        if (cur_cnt > 1) begin
          cur_cnt--;
          moved = 1'b1;
        end
      end
      OP_REDO: begin
        if (cur_cnt < end_cnt) begin
          cur_cnt++;
          moved = 1'b1;
        end
      end
      default: ;
    endcase
    view.entry    = (cur_cnt == 0) ? '0 : hist_ring[AW'((base_slot + cur_cnt - 1) % DEPTH)];
    view.moved    = moved;
    view.can_undo = (cur_cnt > 1);
    view.can_redo = (cur_cnt < end_cnt);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    view_t want;
    if (!rst_ni) begin
      cur_cnt    = 0;
      end_cnt    = 0;
      base_slot  = 0;
      pending_views.delete();
      pending_o  = 0;
      fail_cnt_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_views.size() == 0) begin
          report_mismatch("unexpected word", current_entry_i, '0);
        end else begin
          want = pending_views.pop_front();
          if (current_entry_i !== want.entry)
            report_mismatch("current_entry", current_entry_i, want.entry);
          if (moved_i !== want.moved)
            report_mismatch("moved", ENTRY_W'(moved_i), ENTRY_W'(want.moved));
          if (can_undo_i !== want.can_undo)
            report_mismatch("can_undo", ENTRY_W'(can_undo_i), ENTRY_W'(want.can_undo));
          if (can_redo_i !== want.can_redo)
            report_mismatch("can_redo", ENTRY_W'(can_redo_i), ENTRY_W'(want.can_redo));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        step_history(op_i, entry_data_i, want);
        pending_views.push_back(want);
      end
      pending_o = pending_views.size();
    end
  end

endmodule

// ===== dv/tb_bounded_undo_redo_history.sv =====
// Testbench top of the bounded undo and redo history: clock, reset, stimulus and verdict.
module tb_bounded_undo_redo_history;
  import burh_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;
  localparam int              ITEM_GOAL = 1250;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic [OP_W-1:0]    op_i         = OP_PUSH;
  logic [ENTRY_W-1:0] entry_data_i = '0;
  logic               out_stall_i  = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [ENTRY_W-1:0] current_entry_o;
  logic               moved_o;
  logic               can_undo_o;
  logic               can_redo_o;
  int                 fail_cnt;
  int                 pending_cnt;
  bit                 no_idle      = 1'b0;

  always #4 clk_i = ~clk_i;

  bounded_undo_redo_history dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .entry_data_i   (entry_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .current_entry_o(current_entry_o),
    .moved_o        (moved_o),
    .can_undo_o     (can_undo_o),
    .can_redo_o     (can_redo_o)
  );

  burh_history_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .op_i           (op_i),
    .entry_data_i   (entry_data_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .current_entry_i(current_entry_o),
    .moved_i        (moved_o),
    .can_undo_i     (can_undo_o),
    .can_redo_i     (can_redo_o),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending_cnt)
  );

  always @(posedge clk_i) begin
    out_stall_i <= no_idle ? 1'b0 : ($urandom_range(99) < 16);
  end

  task automatic send_word(input logic [OP_W-1:0] op, input logic [ENTRY_W-1:0] data);
    while (!no_idle && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    entry_data_i <= data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  initial begin
    int sent;
    int pick;
    int len;
    sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty history, single entry, redo at the end mark, redo entries dropped by a push,
    // then filling past the top so that the oldest entry is discarded.
    send_word(OP_UNDO, 32'hFFFF_FFFF);
    send_word(OP_REDO, 32'hFFFF_FFFF);
    send_word(OP_RSVD, 32'h1234_5678);
    send_word(OP_PUSH, 32'h0000_0000);
    send_word(OP_PUSH, 32'hFFFF_FFFF);
    send_word(OP_UNDO, 32'h0);
    send_word(OP_REDO, 32'h0);
    send_word(OP_REDO, 32'h0);
    send_word(OP_UNDO, 32'h0);
    send_word(OP_PUSH, 32'hA5A5_A5A5);
    for (int k = 0; k < 15; k++) send_word(OP_PUSH, $urandom());
    wait_drained();

    while (sent < ITEM_GOAL) begin
      pick = $urandom_range(99);
      len  = $urandom_range(1, 18);
      for (int k = 0; k < len; k++) begin
        no_idle = (sent >= 500 && sent < 700);
        if (pick < 40) send_word(OP_PUSH, $urandom());
        else if (pick < 65) send_word(OP_UNDO, $urandom());
        else if (pick < 85) send_word(OP_REDO, $urandom());
        else send_word(OP_W'($urandom_range(3)), $urandom());
        sent++;
        if (sent % 300 == 0) wait_drained();
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
